// ===== hw/rtl/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and codes for the PID step unit and its serial multiply/divide.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_GAIN_PROP   = 3'd0;
   localparam logic [2:0] CSR_GAIN_INTEG  = 3'd1;
   localparam logic [2:0] CSR_GAIN_DERIV  = 3'd2;
   localparam logic [2:0] CSR_OUT_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_INTEG_LIMIT = 3'd4;
   localparam logic [2:0] CSR_WINDUP_MODE = 3'd5;

   // multiply/divide unit operations
   typedef enum logic {
      MDU_MULR,    // a*b, rounded at the binary point
      MDU_MULDIV   // a*b/c, truncated
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
      logic       neg;
   } mdu_cmd_type;

   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_MUL,
      MDU_DIV,
      MDU_FIN
   } mdu_state_type;

   // step sequencer
   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_PT,
      SQ_DTM,
      SQ_IT,
      SQ_SUM1,
      SQ_GAIN,
      SQ_CORR,
      SQ_INC,
      SQ_IT2,
      SQ_OUT
   } seq_state_type;

endpackage

// ===== hw/rtl/pidaw_mdu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_mdu
// Bit-serial multiply and divide: shift-add product one bit per cycle, then
// either rounding at the binary point or restoring division one quotient
// bit per cycle, and saturation to the signed data range.
// ----------------------------------------------------------------------------
module pidaw_mdu #(
   parameter  int DW = 32,
   parameter  int FB = 16,
   localparam int MB = (FB + 1 > DW) ? FB + 1 : DW,
   localparam int PW = DW + MB
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pidaw_pkg::mdu_cmd_type   cmd,
   input  logic [DW-1:0]            a_mag,
   input  logic [MB-1:0]            b_mag,
   input  logic [DW-1:0]            c_mag,
   output logic                     done,
   output logic signed [DW-1:0]     result
);
   import pidaw_pkg::*;

   localparam int CW = $clog2(PW);
   localparam logic [PW:0] HALF = (PW+1)'(1) << (FB - 1);
   localparam logic [PW:0] LIM_NEG = (PW+1)'(1) << (DW - 1);
   localparam logic [PW:0] LIM_POS = LIM_NEG - (PW+1)'(1);

   mdu_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  p_ff, p_in;
   logic [DW-1:0]  a_ff, a_in;
   logic [DW-1:0]  c_ff, c_in;
   logic [DW-1:0]  r_ff, r_in;
   mdu_op_type     op_ff, op_in;
   logic           neg_ff, neg_in;
   logic           done_ff, done_in;
   logic signed [DW-1:0] res_ff, res_in;

   logic [DW:0]    sum;
   logic [DW:0]    rem_t;
   logic [DW:0]    diff;
   logic           ge;
   logic [PW:0]    q;
   logic [PW:0]    lim;
   logic [DW-1:0]  mag;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MDU_IDLE: if (cmd.start) state_in = MDU_MUL;
         MDU_MUL: begin
            if (cnt_ff == '0) state_in = (op_ff == MDU_MULDIV) ? MDU_DIV : MDU_FIN;
         end
         MDU_DIV: if (cnt_ff == '0) state_in = MDU_FIN;
         MDU_FIN: state_in = MDU_IDLE;
         default: state_in = MDU_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      sum   = {1'b0, p_ff[PW-1:MB]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      rem_t = {r_ff, p_ff[PW-1]};
      diff  = rem_t - {1'b0, c_ff};
      ge    = rem_t >= {1'b0, c_ff};
      q     = (op_ff == MDU_MULR) ? (({1'b0, p_ff} + HALF) >> FB) : {1'b0, p_ff};
      lim   = neg_ff ? LIM_NEG : LIM_POS;
      mag   = (q > lim) ? lim[DW-1:0] : q[DW-1:0];

      cnt_in  = cnt_ff;
      p_in    = p_ff;
      a_in    = a_ff;
      c_in    = c_ff;
      r_in    = r_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      case (state_ff)
         MDU_IDLE: begin
            if (cmd.start) begin
               p_in   = {DW'(0), b_mag};
               a_in   = a_mag;
               c_in   = c_mag;
               op_in  = cmd.op;
               neg_in = cmd.neg;
               cnt_in = CW'(MB - 1);
            end
         end
         MDU_MUL: begin
            p_in   = {sum, p_ff[MB-1:1]};
            cnt_in = (cnt_ff == '0) ? CW'(PW - 1) : cnt_ff - CW'(1);
            r_in   = '0;
         end
         MDU_DIV: begin
            r_in   = ge ? diff[DW-1:0] : rem_t[DW-1:0];
            p_in   = {p_ff[PW-2:0], ge};
            cnt_in = cnt_ff - CW'(1);
         end
         MDU_FIN: begin
            res_in  = neg_ff ? -signed'(mag) : signed'(mag);
            done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MDU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      p_ff   <= p_in;
      a_ff   <= a_in;
      c_ff   <= c_in;
      r_ff   <= r_in;
      op_ff  <= op_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== hw/rtl/pid_step_anti_windup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_anti_windup_unit
// PID controller step with clamped output and optional back-calculation
// anti-windup, signed fixed point with saturating arithmetic.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Every product and quotient runs through one
// shared bit-serial multiply/divide unit, one bit per cycle, so that unit
// sets the rate, along with any wait of the output register on rsp_ready; the
// unit works on MB = max(DATA_WIDTH, FRAC_BITS+1) bit multipliers and
// PW = DATA_WIDTH+MB bit products. Plain mode runs the proportional product,
// the derivative quotient, the integral product, the integrator increment and
// the refreshed integral product; back-calculation mode adds a correction
// product and, with nonzero integral gain, the gain quotient Kp/Ki before it.
// A nonpositive step_time gives a zero drive with the integrator and last
// error untouched. A new beat is taken only once the previous result is in the
// output register, and may be taken while that result still waits there.
// ----------------------------------------------------------------------------
module pid_step_anti_windup_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_measured,
   input  logic signed [31:0] req_step_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import pidaw_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int MB = (FRAC_BITS + 1 > DW) ? FRAC_BITS + 1 : DW;
   localparam int XW = ((DW > 32) ? DW : 32) + 3;
   localparam logic signed [XW-1:0] SMAX_X = (XW'(1) <<< (DW - 1)) - XW'(1);
   localparam logic signed [XW-1:0] SMIN_X = -SMAX_X - XW'(1);

   function automatic logic signed [XW-1:0] ext(input logic signed [DW-1:0] v);
      return XW'(v);
   endfunction

   function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      r = (v > SMAX_X) ? SMAX_X : ((v < SMIN_X) ? SMIN_X : v);
      return r[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      return sat_x(x);
   endfunction

   function automatic logic signed [DW-1:0] clamp_x(input logic signed [XW-1:0] v,
                                                    input logic [30:0] lim);
      logic signed [XW-1:0] l;
      logic signed [XW-1:0] r;
      l = signed'(XW'(lim));
      r = (v < -l) ? -l : ((v > l) ? l : v);
      return r[DW-1:0];
   endfunction

   function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   // configuration registers
   logic signed [31:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [30:0]        out_limit_ff, integ_limit_ff;
   logic               windup_mode_ff;

   // sequencer and datapath registers
   seq_state_type        state_ff, state_in;
   logic                 issued_ff, issued_in;
   logic                 zero_ff, zero_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] prev_ff, prev_in;
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [DW-1:0] dt_ff, dt_in;
   logic signed [DW-1:0] pt_ff, pt_in;
   logic signed [DW-1:0] dtm_ff, dtm_in;
   logic signed [DW-1:0] it_ff, it_in;
   logic signed [DW-1:0] raw_ff, raw_in;
   logic signed [DW-1:0] clamp_ff, clamp_in;
   logic signed [DW-1:0] g_ff, g_in;
   logic signed [DW-1:0] e2_ff, e2_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_drive_ff, rsp_drive_in;

   logic signed [DW-1:0] kp, ki, kd;
   logic signed [DW-1:0] new_err, new_dt, delta_err, back_err;
   logic signed [DW-1:0] raw_sum, out_clamp;
   logic signed [XW-1:0] drive_x;
   logic                 accept, mul_state, out_free;

   // unit operands
   mdu_cmd_type          cmd;
   logic signed [DW-1:0] op_x, op_y, op_z;
   logic                 op_unit;
   logic [MB-1:0]        b_mag;
   logic                 mdu_done;
   logic signed [DW-1:0] mdu_res;

   assign kp = sat_in(gain_prop_ff);
   assign ki = sat_in(gain_integ_ff);
   assign kd = sat_in(gain_deriv_ff);

   assign req_ready = (state_ff == SQ_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign new_err   = sat_x(ext(sat_in(req_target)) - ext(sat_in(req_measured)));
   assign new_dt    = sat_in(req_step_time);
   assign delta_err = sat_x(ext(err_ff) - ext(prev_ff));
   assign back_err  = sat_x(ext(clamp_ff) - ext(raw_ff));
   assign raw_sum   = sat_x(ext(pt_ff) + ext(it_ff) + ext(dtm_ff));
   assign out_clamp = clamp_x(ext(raw_sum), out_limit_ff);
   assign drive_x   = zero_ff ? '0 : ext(out_clamp);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= '0;
         gain_integ_ff  <= '0;
         gain_deriv_ff  <= '0;
         out_limit_ff   <= '1;
         integ_limit_ff <= '1;
         windup_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata;
            CSR_GAIN_INTEG:  gain_integ_ff  <= csr_wdata;
            CSR_GAIN_DERIV:  gain_deriv_ff  <= csr_wdata;
            CSR_OUT_LIMIT:   out_limit_ff   <= csr_wdata[30:0];
            CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata[30:0];
            CSR_WINDUP_MODE: windup_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (accept) state_in = (new_dt[DW-1] || new_dt == '0) ? SQ_OUT : SQ_PT;
         end
         SQ_PT:   if (mdu_done) state_in = SQ_DTM;
         SQ_DTM:  if (mdu_done) state_in = SQ_IT;
         SQ_IT:   if (mdu_done) state_in = SQ_SUM1;
         SQ_SUM1: begin
            if (!windup_mode_ff)  state_in = SQ_INC;
            else if (ki != '0)    state_in = SQ_GAIN;
            else                  state_in = SQ_CORR;
         end
         SQ_GAIN: if (mdu_done) state_in = SQ_CORR;
         SQ_CORR: if (mdu_done) state_in = SQ_INC;
         SQ_INC:  if (mdu_done) state_in = SQ_IT2;
         SQ_IT2:  if (mdu_done) state_in = SQ_OUT;
         SQ_OUT:  if (out_free) state_in = SQ_IDLE;
         default: state_in = SQ_IDLE;
      endcase
   end

   // unit operand select per step
   always_comb begin
      op_x    = '0;
      op_y    = '0;
      op_z    = '0;
      op_unit = 1'b0;
      cmd.op  = MDU_MULR;
      case (state_ff)
         SQ_PT: begin
            op_x = kp;
            op_y = err_ff;
         end
         SQ_DTM: begin
            op_x   = kd;
            op_y   = delta_err;
            op_z   = dt_ff;
            cmd.op = MDU_MULDIV;
         end
         SQ_IT, SQ_IT2: begin
            op_x = ki;
            op_y = acc_ff;
         end
         SQ_GAIN: begin
            op_x    = kp;
            op_z    = ki;
            op_unit = 1'b1;
            cmd.op  = MDU_MULDIV;
         end
         SQ_CORR: begin
            op_x = g_ff;
            op_y = back_err;
         end
         SQ_INC: begin
            op_x = e2_ff;
            op_y = dt_ff;
         end
         default: ;
      endcase
      mul_state = (state_ff == SQ_PT) || (state_ff == SQ_DTM) || (state_ff == SQ_IT)
               || (state_ff == SQ_GAIN) || (state_ff == SQ_CORR)
               || (state_ff == SQ_INC) || (state_ff == SQ_IT2);
      cmd.start = mul_state && !issued_ff;
      cmd.neg   = (op_x[DW-1] ^ (op_y[DW-1] && !op_unit))
                ^ ((cmd.op == MDU_MULDIV) && op_z[DW-1]);
      b_mag     = op_unit ? (MB'(1) << FRAC_BITS) : MB'(mag(op_y));
   end

   // datapath register updates
   always_comb begin
      issued_in    = issued_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      pt_in        = pt_ff;
      dtm_in       = dtm_ff;
      it_in        = it_ff;
      raw_in       = raw_ff;
      clamp_in     = clamp_ff;
      g_in         = g_ff;
      e2_in        = e2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_drive_in = rsp_drive_ff;

      if (cmd.start) issued_in = 1'b1;
      if (mdu_done)  issued_in = 1'b0;

      case (state_ff)
         SQ_IDLE: begin
            if (accept) begin
               err_in  = new_err;
               dt_in   = new_dt;
               zero_in = new_dt[DW-1] || new_dt == '0;
            end
         end
         SQ_PT:   if (mdu_done) pt_in  = mdu_res;
         SQ_DTM:  if (mdu_done) dtm_in = mdu_res;
         SQ_IT:   if (mdu_done) it_in  = mdu_res;
         SQ_SUM1: begin
            raw_in   = raw_sum;
            clamp_in = out_clamp;
            g_in     = '0;
            e2_in    = err_ff;
         end
         SQ_GAIN: if (mdu_done) g_in = mdu_res;
         SQ_CORR: if (mdu_done) e2_in = sat_x(ext(err_ff) + ext(mdu_res));
         SQ_INC: begin
            if (mdu_done) acc_in = clamp_x(ext(sat_x(ext(acc_ff) + ext(mdu_res))),
                                           integ_limit_ff);
         end
         SQ_IT2:  if (mdu_done) it_in = mdu_res;
         SQ_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_x[31:0];
               if (!zero_ff) prev_in = err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
      end
      zero_ff      <= zero_in;
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      pt_ff        <= pt_in;
      dtm_ff       <= dtm_in;
      it_ff        <= it_in;
      raw_ff       <= raw_in;
      clamp_ff     <= clamp_in;
      g_ff         <= g_in;
      e2_ff        <= e2_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   pidaw_mdu #(
      .DW (DW),
      .FB (FRAC_BITS)
   ) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .a_mag  (mag(op_x)),
      .b_mag  (b_mag),
      .c_mag  (mag(op_z)),
      .done   (mdu_done),
      .result (mdu_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule
